// ===== rtl/djs_pkg.sv =====
// ----------------------------------------------------------------------------
// djs_pkg
// Shared widths and limits of the deadline job sequencer.
// ----------------------------------------------------------------------------
package djs_pkg;

  localparam int DUE_W   = 11;
  localparam int SCORE_W = 16;
  localparam int SUM_W   = 26;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

// ===== rtl/djs_day_ram.sv =====
// ----------------------------------------------------------------------------
// djs_day_ram
// Single-bit day occupancy memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module djs_day_ram #(
  parameter int Depth = 1025,
  parameter int AddrW = 11
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic             wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic             rd_data_o
);

  logic mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/deadline_job_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// deadline_job_sequencer_top
// Greedy job sequencing with deadlines over a task memory and a day map.
// ----------------------------------------------------------------------------
// Tasks load at one word per cycle while in_ready_o is high. After the word
// flagged last, the block picks tasks highest score first (ties to the later
// deadline) by scanning the task memory once per pick, then walks the day map
// backward from the deadline. Each memory has a single read port. After each
// result, and after reset, a clearing pass wipes every day of the day map,
// 0 to MAX_DAY; no word is taken during it.
module deadline_job_sequencer_top #(
  parameter int MAX_TASKS = 1024,
  parameter int MAX_DAY   = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [djs_pkg::DUE_W-1:0]   due_day_i,
  input  logic [djs_pkg::SCORE_W-1:0] task_score_i,
  input  logic                        last_task_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [djs_pkg::SUM_W-1:0]   total_score_o
);
  import djs_pkg::*;

  localparam int TIW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNTW = $clog2(MAX_TASKS + 1);
  localparam int DW   = $clog2(MAX_DAY + 1);
  localparam int CW   = (DW > DUE_W) ? DW : DUE_W;
  localparam int EW   = SCORE_W + DW;
  localparam int KW   = EW + TIW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [CNTW-1:0]    ptr_q, ptr_d;
  logic               pend_q, pend_d;
  logic [TIW-1:0]     pidx_q, pidx_d;
  logic               first_q, first_d;
  logic               found_q, found_d;
  logic [KW-1:0]      best_q, best_d;
  logic [KW-1:0]      prev_q, prev_d;
  logic [DW-1:0]      day_q, day_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  logic [SUM_W-1:0]   out_q, out_d;

  logic [EW-1:0]      task_mem_q [MAX_TASKS];
  logic [EW-1:0]      task_rd_q;
  logic               task_wr;
  logic               task_rd;

  logic               day_wr, day_wr_data, day_rd, day_taken;
  logic [DW-1:0]      day_wr_addr;

  logic [CW-1:0]      due_ext;
  logic [DW-1:0]      due_sat;
  logic [KW-1:0]      cand;
  logic [SUM_W:0]     add_sum;

  assign due_ext = CW'(due_day_i);
  assign due_sat = (due_ext > CW'(MAX_DAY)) ? DW'(MAX_DAY) : DW'(due_ext);
  assign cand    = {task_rd_q, pidx_q};
  assign add_sum = {1'b0, sum_q} + (SUM_W + 1)'(best_q[KW-1 -: SCORE_W]);

  assign in_ready_o    = (state_q == S_LOAD);
  assign out_valid_o   = out_valid_q;
  assign total_score_o = out_q;

  assign task_wr = in_valid_i && in_ready_o && (cnt_q < CNTW'(MAX_TASKS));
  assign task_rd = (state_q == S_SCAN) && (ptr_q < cnt_q);

  always_ff @(posedge clk_i) begin
    if (task_wr) begin
      task_mem_q[cnt_q[TIW-1:0]] <= {task_score_i, due_sat};
    end
    if (task_rd) begin
      task_rd_q <= task_mem_q[ptr_q[TIW-1:0]];
    end
  end

  assign day_wr      = (state_q == S_CLEAR) || ((state_q == S_CHK) && !day_taken);
  assign day_wr_data = (state_q != S_CLEAR);
  assign day_wr_addr = day_q;
  assign day_rd      = (state_q == S_SRCH) && (day_q != '0);

  djs_day_ram #(
    .Depth (MAX_DAY + 1),
    .AddrW (DW)
  ) u_day_ram (
    .clk_i     (clk_i),
    .wr_en_i   (day_wr),
    .wr_addr_i (day_wr_addr),
    .wr_data_i (day_wr_data),
    .rd_en_i   (day_rd),
    .rd_addr_i (day_q),
    .rd_data_o (day_taken)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    first_d     = first_q;
    found_d     = found_q;
    best_d      = best_q;
    prev_d      = prev_q;
    day_d       = day_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        if (day_q == DW'(MAX_DAY)) begin
          state_d = S_LOAD;
        end else begin
          day_d = day_q + 1'b1;
        end
      end
      S_LOAD: begin
        if (in_valid_i) begin
          if (task_wr) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (last_task_i) begin
            state_d = S_SCAN;
            ptr_d   = '0;
            first_d = 1'b1;
            found_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (task_rd) begin
          ptr_d  = ptr_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q[TIW-1:0];
        end
        if (pend_q && (first_q || cand < prev_q) && (!found_q || cand > best_q)) begin
          found_d = 1'b1;
          best_d  = cand;
        end
        if (!task_rd && !pend_q) begin
          if (found_q) begin
            state_d = S_SRCH;
            prev_d  = best_q;
            first_d = 1'b0;
            day_d   = best_q[TIW +: DW];
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SRCH: begin
        if (day_q == '0) begin
          state_d = S_SCAN;
          ptr_d   = '0;
          found_d = 1'b0;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (day_taken) begin
          day_d   = day_q - 1'b1;
          state_d = S_SRCH;
        end else begin
          sum_d   = add_sum[SUM_W] ? SUM_MAX : add_sum[SUM_W-1:0];
          state_d = S_SCAN;
          ptr_d   = '0;
          found_d = 1'b0;
        end
      end
      S_DONE: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_d       = sum_q;
          sum_d       = '0;
          cnt_d       = '0;
          day_d       = '0;
          state_d     = S_CLEAR;
        end
      end
      default: begin
        state_d = S_CLEAR;
        day_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      first_q     <= 1'b1;
      found_q     <= 1'b0;
      day_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      first_q     <= first_d;
      found_q     <= found_d;
      day_q       <= day_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    best_q <= best_d;
    prev_q <= prev_d;
    out_q  <= out_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MAX_TASKS))
    else $error("task count beyond store depth");

  a_day_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    day_q <= DW'(MAX_DAY))
    else $error("day pointer beyond day map");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside done state");

  a_chk_after_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> $past(state_q) == S_SRCH && $past(day_q) != '0)
    else $error("day check without a read");

endmodule
